@@ hw/rtl/wmmpc_pkg.sv @@
// Shared types and constants for the 3x3 mean/median pixel correction block.
// No dependencies; imported by wmmpc_recon and the top level.
`default_nettype none

package wmmpc_pkg;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic       flush;
    } in_item_t;

    typedef struct packed {
        logic [7:0] corrected_value;
        logic       frame_last;
    } out_item_t;

    // Per-pixel neighborhood info that travels with the window
    typedef struct packed {
        logic valid;
        logic frame_last;
        logic row_top;
        logic row_bot;
        logic col_left;
        logic col_right;
    } win_ctl_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [11:0] IMAGE_HEIGHT_RST = 12'd480;

    localparam logic [15:0] IN_ROW_CAP = 16'hFFFF;

    // fixed point: values in units of 1/216
    localparam logic [7:0]  SCALE     = 8'd216;
    localparam logic [16:0] TOL       = 17'd216;
    localparam logic [9:0]  DIV_BY    = 10'd648;
    // floor(V/648) == (V * DIV_MUL) >> DIV_SHIFT for V < 2^18
    localparam logic [18:0] DIV_MUL   = 19'd414253;
    localparam int          DIV_SHIFT = 28;

    // 216/n for the neighborhood sizes that occur
    function automatic logic [7:0] mean_factor(input logic [3:0] n);
        logic [7:0] f;
        case (n)
            4'd1:    f = 8'd216;
            4'd2:    f = 8'd108;
            4'd3:    f = 8'd72;
            4'd4:    f = 8'd54;
            4'd6:    f = 8'd36;
            4'd9:    f = 8'd24;
            default: f = 8'd0;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/window_mean_median_pixel_correct_top.sv @@
// Top level: raster control, row store memory, 3x3 window and output buffer.
// Depends on wmmpc_pkg and wmmpc_recon.
//
//   port group   dir  handshake            payload
//   in_*         in   in_valid / in_stall  in_item  (pixel_value, flush)
//   out_*        out  out_valid / out_stall out_item (corrected_value, frame_last)
//   cfg_*        in   cfg_wr_en            cfg_index, cfg_data
//
// One item per clock while in_stall is low. A result passes stage s1, the window,
// recon stages A to D and the output buffer. The row store is one memory, read
// when an item is taken and written from stage s1 as it advances; a back-to-back
// hit on the same column is forwarded from the writing item. in_stall rises only
// while the 2-entry output buffer is full and another result is at the end of the
// pipeline. Reset clears control state and the window, not the row store.
`default_nettype none

module window_mean_median_pixel_correct_top
    import wmmpc_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_item,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WB  = $clog2(MAX_WIDTH + 1);
    localparam int CW  = ((WB > 11) ? WB : 11) + 1;
    localparam logic [CW-1:0] MAXW = CW'(MAX_WIDTH);

    // ---------------- configuration
    logic [10:0] iw_reg;
    logic [11:0] ih_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iw_reg <= IMAGE_WIDTH_RST;
            ih_reg <= IMAGE_HEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  iw_reg <= cfg_data[10:0];
                REG_IMAGE_HEIGHT: ih_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    logic [CW-1:0] eff_w;
    logic [11:0]   eff_h;

    always_comb
    begin
        if (iw_reg == '0)
            eff_w = CW'(1);
        else if (CW'(iw_reg) > MAXW)
            eff_w = MAXW;
        else
            eff_w = CW'(iw_reg);
        eff_h = (ih_reg == '0) ? 12'd1 : ih_reg;
    end

    // ---------------- raster counters
    logic          en;
    logic          accept;
    logic          take;
    logic          pixels_due;
    logic          emit;
    logic [7:0]    pix;
    logic          in_wrap;
    logic          out_col_last;
    logic          out_row_last;
    logic          frame_end;

    logic [AW-1:0] in_col_reg,  in_col_next;
    logic [15:0]   in_row_reg,  in_row_next;
    logic [AW-1:0] out_col_reg, out_col_next;
    logic [11:0]   out_row_reg, out_row_next;

    always_comb
    begin
        accept       = in_valid && !in_stall;
        pixels_due   = in_row_reg < {4'd0, eff_h};
        take         = accept && !(in_item.flush && pixels_due);
        pix          = (pixels_due && !in_item.flush) ? in_item.pixel_value : 8'd0;
        emit         = (in_row_reg >= 16'd2) ||
                       (in_row_reg == 16'd1 && in_col_reg != '0);
        in_wrap      = (CW'(in_col_reg) + CW'(1)) >= eff_w;
        out_col_last = (CW'(out_col_reg) + CW'(1)) >= eff_w;
        out_row_last = ({1'b0, out_row_reg} + 13'd1) >= {1'b0, eff_h};
        frame_end    = out_row_last && out_col_last;

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (take)
        begin
            if (in_wrap)
            begin
                in_col_next = '0;
                if (in_row_reg != IN_ROW_CAP)
                    in_row_next = in_row_reg + 16'd1;
            end
            else
                in_col_next = in_col_reg + AW'(1);
            if (emit)
            begin
                if (frame_end)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_col_last)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 12'd1;
                end
                else
                    out_col_next = out_col_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ---------------- row store: [7:0] upper row, [15:8] middle row
    logic [15:0]   row_mem [MAX_WIDTH];
    logic [15:0]   rd_q;
    logic [15:0]   rd_eff;
    logic [15:0]   wr_data;

    logic          s1_valid_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [7:0]    s1_pix_reg;
    win_ctl_t      s1_ctl_reg;
    logic          fwd_reg;
    logic [15:0]   fwd_data_reg;

    assign rd_eff  = fwd_reg ? fwd_data_reg : rd_q;
    assign wr_data = {s1_pix_reg, rd_eff[15:8]};

    always_ff @(posedge clk)
    begin
        if (take)
            rd_q <= row_mem[in_col_reg];
        if (en && s1_valid_reg)
            row_mem[s1_addr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= take;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_addr_reg          <= in_col_reg;
            s1_pix_reg           <= pix;
            s1_ctl_reg.valid     <= emit;
            s1_ctl_reg.frame_last <= frame_end;
            s1_ctl_reg.row_top   <= out_row_reg != '0;
            s1_ctl_reg.row_bot   <= !out_row_last;
            s1_ctl_reg.col_left  <= out_col_reg != '0;
            s1_ctl_reg.col_right <= !out_col_last;
            // item ahead writes this column at the same edge as our read
            fwd_reg              <= s1_valid_reg && (s1_addr_reg == in_col_reg);
            fwd_data_reg         <= wr_data;
        end
    end

    // ---------------- 3x3 window
    logic [2:0][2:0][7:0] win_reg;
    win_ctl_t             win_ctl_reg;
    win_ctl_t             win_ctl_next;

    always_comb
    begin
        win_ctl_next       = s1_ctl_reg;
        win_ctl_next.valid = s1_valid_reg && s1_ctl_reg.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg     <= '0;
            win_ctl_reg <= '0;
        end
        else if (en)
        begin
            win_ctl_reg <= win_ctl_next;
            if (s1_valid_reg)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= rd_eff[7:0];
                win_reg[1][2] <= rd_eff[15:8];
                win_reg[2][2] <= s1_pix_reg;
            end
        end
    end

    logic      res_valid;
    out_item_t res;

    wmmpc_recon u_recon (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .win       (win_reg),
        .ctl       (win_ctl_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // ---------------- 2-entry output buffer
    out_item_t   obuf [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        push;
    logic        pop;

    assign en        = !(cnt_reg == 2'd2 && res_valid);
    assign in_stall  = !en;
    assign push      = en && res_valid;
    assign out_valid = cnt_reg != 2'd0;
    assign pop       = out_valid && !out_stall;
    assign out_item  = obuf[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            obuf[wr_ptr_reg] <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg != 2'd2))
        else $error("output buffer overflow");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (cnt_reg == 2'd2 && res_valid))
        else $error("input stalled with room in output buffer");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (CW'(in_col_reg) < MAXW) && (CW'(out_col_reg) < MAXW))
        else $error("column counter out of range");

    a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
        (take && s1_valid_reg && s1_addr_reg == in_col_reg) |=> fwd_reg)
        else $error("missed row store forward");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/wmmpc_recon.sv @@
// Reconstruction pipeline: 3x3 window -> mean, median, correction, rounded /3.
// Depends on wmmpc_pkg.
`default_nettype none

module wmmpc_recon
    import wmmpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic [2:0][2:0][7:0] win,
    input  win_ctl_t             ctl,
    output logic                 res_valid,
    output out_item_t            res
);

    // ---------------- stage A: mask, sum, count, median by rank
    logic [8:0]       msk;
    logic [8:0][7:0]  vals;
    logic [11:0]      sum_c;
    logic [3:0]       n_c;
    logic [8:0][3:0]  rank;
    logic [7:0]       med_c;
    logic [2:0]       rok;
    logic [2:0]       cok;

    always_comb
    begin
        rok = {ctl.row_bot, 1'b1, ctl.row_top};
        cok = {ctl.col_right, 1'b1, ctl.col_left};
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                msk[r*3+c]  = rok[r] & cok[c];
                vals[r*3+c] = win[r][c];
            end
        end
        sum_c = '0;
        n_c   = '0;
        for (int k = 0; k < 9; k++)
        begin
            if (msk[k])
            begin
                sum_c = sum_c + 12'(vals[k]);
                n_c   = n_c + 4'd1;
            end
        end
        // stable rank among the in-image values; ties broken by position
        for (int k = 0; k < 9; k++)
        begin
            rank[k] = '0;
            for (int j = 0; j < 9; j++)
            begin
                if (j != k && msk[j] &&
                    (vals[j] < vals[k] || (vals[j] == vals[k] && j < k)))
                    rank[k] = rank[k] + 4'd1;
            end
        end
        med_c = '0;
        for (int k = 0; k < 9; k++)
        begin
            if (msk[k] && rank[k] == (n_c >> 1))
                med_c = med_c | vals[k];
        end
    end

    logic        a_valid_reg;
    logic        a_last_reg;
    logic [11:0] a_sum_reg;
    logic [3:0]  a_n_reg;
    logic [7:0]  a_med_reg;
    logic [7:0]  a_ctr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_last_reg <= ctl.frame_last;
            a_sum_reg  <= sum_c;
            a_n_reg    <= n_c;
            a_med_reg  <= med_c;
            a_ctr_reg  <= win[1][1];
        end
    end

    // ---------------- stage B: scale to 1/216 units
    logic [19:0] g_prod;
    logic        b_valid_reg;
    logic        b_last_reg;
    logic [15:0] b_f_reg;
    logic [15:0] b_g_reg;
    logic [15:0] b_h_reg;

    assign g_prod = a_sum_reg * mean_factor(a_n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (en)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_last_reg <= a_last_reg;
            b_f_reg    <= a_ctr_reg * SCALE;
            b_h_reg    <= a_med_reg * SCALE;
            b_g_reg    <= g_prod[15:0];
        end
    end

    // ---------------- stage C: outlier correction, sum of three
    logic [15:0] dfg;
    logic [15:0] dfh;
    logic [15:0] dgh;
    logic [15:0] f_c;
    logic [15:0] g_c;
    logic [16:0] gh_sum;
    logic [16:0] fh_sum;
    logic [17:0] v_c;
    logic        c_valid_reg;
    logic        c_last_reg;
    logic [17:0] c_v_reg;

    always_comb
    begin
        dfg    = (b_f_reg > b_g_reg) ? b_f_reg - b_g_reg : b_g_reg - b_f_reg;
        dfh    = (b_f_reg > b_h_reg) ? b_f_reg - b_h_reg : b_h_reg - b_f_reg;
        dgh    = (b_g_reg > b_h_reg) ? b_g_reg - b_h_reg : b_h_reg - b_g_reg;
        gh_sum = 17'(b_g_reg) + 17'(b_h_reg);
        fh_sum = 17'(b_f_reg) + 17'(b_h_reg);
        f_c    = b_f_reg;
        g_c    = b_g_reg;
        if (17'(dfg) > 17'(dgh) + TOL && 17'(dfh) > 17'(dgh) + TOL)
            f_c = gh_sum[16:1];
        else if (17'(dfg) > 17'(dfh) + TOL && 17'(dgh) > 17'(dfh) + TOL)
            g_c = fh_sum[16:1];
        else if (17'(dfh) > 17'(dfg) + TOL && 17'(dgh) > 17'(dfg) + TOL)
        begin
            f_c = b_h_reg;
            g_c = b_h_reg;
        end
        v_c = 18'(f_c) + 18'(g_c) + 18'(b_h_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_last_reg <= b_last_reg;
            c_v_reg    <= v_c;
        end
    end

    // ---------------- stage D: reciprocal multiply for /648
    logic        d_valid_reg;
    logic        d_last_reg;
    logic [17:0] d_v_reg;
    logic [36:0] d_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (en)
            d_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_last_reg <= c_last_reg;
            d_v_reg    <= c_v_reg;
            d_prod_reg <= c_v_reg * DIV_MUL;
        end
    end

    // ---------------- round to nearest, ties to even
    logic [8:0]  q_fl;
    logic [17:0] q_x648;
    logic [17:0] rem_w;
    logic [10:0] rem2;
    logic [8:0]  q_rnd;

    always_comb
    begin
        q_fl   = d_prod_reg[DIV_SHIFT+8:DIV_SHIFT];
        q_x648 = {q_fl, 9'd0} + {2'd0, q_fl, 7'd0} + {6'd0, q_fl, 3'd0};
        rem_w  = d_v_reg - q_x648;
        rem2   = {rem_w[9:0], 1'b0};
        q_rnd  = q_fl;
        if (rem2 > 11'(DIV_BY) || (rem2 == 11'(DIV_BY) && q_fl[0]))
            q_rnd = q_fl + 9'd1;
        res.corrected_value = q_rnd[8] ? 8'hFF : q_rnd[7:0];
        res.frame_last      = d_last_reg;
    end

    assign res_valid = d_valid_reg;

endmodule

`default_nettype wire
